@@ design/gmm_pkg.sv @@
`default_nettype none
package gmm_pkg;
	localparam int NumComp = 3;
	localparam int CompW = $clog2(NumComp);
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] RegMatchMult = 3'd0;
	localparam logic [CfgIdxW-1:0] RegLearnRate = 3'd1;
	localparam logic [CfgIdxW-1:0] RegBgFrac    = 3'd2;
	localparam logic [CfgIdxW-1:0] RegNewSpread = 3'd3;
	localparam logic [CfgIdxW-1:0] RegNewWeight = 3'd4;

	localparam logic [15:0] ResetMatchMult = 16'd640;
	localparam logic [15:0] ResetLearnRate = 16'd655;
	localparam logic [15:0] ResetBgFrac    = 16'd45875;
	localparam logic [15:0] ResetNewSpread = 16'd12800;
	localparam logic [15:0] ResetNewWeight = 16'd6554;
	localparam logic [15:0] ResetWeight    = 16'(65536 / NumComp);

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,    // latch sample, clear scan
		OP_CLASS,   // one step of the table build or the weight-order walk
		OP_PRIO,    // one step of the priority-order search
		OP_PICK,    // choose slot, start weight update
		OP_WUPD,    // weight product
		OP_DIV,     // one quotient bit of the shared divider
		OP_RATE,    // take r from divider
		OP_MEAN,    // mean update
		OP_VAR,     // variance terms
		OP_VSUM,    // variance sum, start square root
		OP_SQRT,    // one square root step
		OP_WRITE,   // write back component
		OP_NSUM,    // renormalize: sum weights
		OP_NDIV,    // renormalize: start divide for one slot
		OP_NSTORE   // renormalize: store one weight
	} op_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic hit;
		logic sum_zero;
		logic scan_last;
	} status_t;
endpackage
`default_nettype wire

@@ design/gaussian_mixture_background_model_top.sv @@
// Per-pixel mixture-of-Gaussians background model. Each request carries one
// 8-bit sample and yields one result (foreground, matched, component_index).
// Items are processed one at a time, mostly in 48-step restoring divisions
// (one for the learning rate, one per component for renormalization), a
// 17-step square root and a K*K pairwise table that builds the rankings; a
// replaced component skips the learning-rate division and square root. A
// finished result is held in an output register; the next sample is taken
// while it waits. Write configuration only while idle.
`default_nettype none
module gaussian_mixture_background_model_top import gmm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	input  wire logic                valid_in,
	output logic                     ready_in,
	input  wire logic [7:0]          sample,
	output logic                     valid_out,
	input  wire logic                ready_out,
	output logic                     foreground,
	output logic                     matched,
	output logic [2:0]               component_index
);
	op_t     op;
	status_t st;
	logic    busy, done, fg, hit;
	logic [CompW-1:0] slot;

	assign ready_in = !busy;

	gmm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(valid_in), .out_busy(valid_out && !ready_out),
		.st(st), .op(op), .busy(busy), .done(done)
	);

	gmm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .sample(sample),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.st(st), .fg_q(fg), .hit_q(hit), .slot_q(slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
			foreground <= 1'b0;
			matched <= 1'b0;
			component_index <= '0;
		end else begin
			if (valid_out && ready_out) valid_out <= 1'b0;
			if (done) begin
				valid_out <= 1'b1;
				foreground <= fg;
				matched <= hit;
				component_index <= 3'(slot);
			end
		end
	end
endmodule
`default_nettype wire

@@ design/gmm_ctrl.sv @@
`default_nettype none
module gmm_ctrl import gmm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire logic    out_busy,
	input  wire status_t st,
	output op_t          op,
	output logic         busy,
	output logic         done
);
	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_CLASS = 14'b00000000000010,
		S_PRIO  = 14'b00000000000100,
		S_PICK  = 14'b00000000001000,
		S_WUPD  = 14'b00000000010000,
		S_RDIV  = 14'b00000000100000,
		S_RATE  = 14'b00000001000000,
		S_MEAN  = 14'b00000010000000,
		S_VAR   = 14'b00000100000000,
		S_SQRT  = 14'b00001000000000,
		S_WRITE = 14'b00010000000000,
		S_NSUM  = 14'b00100000000000,
		S_NDIV  = 14'b01000000000000,
		S_DONE  = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   ndiv_run_q, ndiv_run_d;
	logic   vsum_q, vsum_d;

	always_comb begin
		state_d = state_q;
		ndiv_run_d = ndiv_run_q;
		vsum_d = vsum_q;
		op = OP_NONE;
		done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op = OP_LOAD;
					state_d = S_CLASS;
				end
			end
			S_CLASS: begin
				op = OP_CLASS;
				if (st.scan_last) state_d = S_PRIO;
			end
			S_PRIO: begin
				op = OP_PRIO;
				if (st.scan_last) state_d = S_PICK;
			end
			S_PICK: begin
				op = OP_PICK;
				state_d = st.hit ? S_WUPD : S_WRITE;
			end
			S_WUPD: begin
				op = OP_WUPD;
				state_d = S_RDIV;
			end
			S_RDIV: begin
				if (st.div_done) state_d = S_RATE;
				else op = OP_DIV;
			end
			S_RATE: begin
				op = OP_RATE;
				state_d = S_MEAN;
			end
			S_MEAN: begin
				op = OP_MEAN;
				state_d = S_VAR;
				vsum_d = 1'b0;
			end
			S_VAR: begin
				op = vsum_q ? OP_VSUM : OP_VAR;
				vsum_d = 1'b1;
				if (vsum_q) state_d = S_SQRT;
			end
			S_SQRT: begin
				if (st.sqrt_done) state_d = S_WRITE;
				else op = OP_SQRT;
			end
			S_WRITE: begin
				op = OP_WRITE;
				state_d = S_NSUM;
			end
			S_NSUM: begin
				op = OP_NSUM;
				state_d = S_NDIV;
				ndiv_run_d = 1'b0;
			end
			S_NDIV: begin
				if (st.sum_zero) begin
					state_d = S_DONE;
				end else if (!ndiv_run_q) begin
					op = OP_NDIV;
					ndiv_run_d = 1'b1;
				end else if (!st.div_done) begin
					op = OP_DIV;
				end else begin
					op = OP_NSTORE;
					ndiv_run_d = 1'b0;
					if (st.scan_last) state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_busy) begin
					done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ndiv_run_q <= 1'b0;
			vsum_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ndiv_run_q <= ndiv_run_d;
			vsum_q <= vsum_d;
		end
	end
endmodule
`default_nettype wire

@@ design/gmm_datapath.sv @@
`default_nettype none
module gmm_datapath import gmm_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire op_t             op,
	input  wire logic [7:0]      sample,
	input  wire logic            cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	output status_t              st,
	output logic                 fg_q,
	output logic                 hit_q,
	output logic [CompW-1:0]     slot_q
);
	logic [11:0] mult_q;
	logic [15:0] alpha_q, bgfrac_q, nspread_q, nweight_q;
	logic [15:0] mean_q [NumComp];
	logic [15:0] spread_q [NumComp];
	logic [15:0] weight_q [NumComp];
	logic [15:0] xs_q;
	logic [CompW-1:0] idx_q;
	// rank position counters
	logic [CompW:0] cnt_q;
	logic [16:0] cum_q;
	logic [CompW-1:0] last_q;
	// working values
	logic [15:0] w_q, m_q, s_q;
	logic [16:0] r_q;
	logic [33:0] prod_q;
	logic [47:0] v1_q;
	logic [31:0] v2_q;
	logic [47:0] rem_q;
	logic [31:0] den_q, quo_q;
	logic [5:0]  dcnt_q;
	logic [47:0] dnum_q;
	logic [47:0] sv_q, sres_q, sbit_q;
	logic [17:0] sum_q;

	logic [CompW-1:0] word [NumComp];
	logic [CompW-1:0] pord [NumComp];
	logic [NumComp-1:0] mt;
	logic [CompW-1:0] wsel, psel;
	logic [15:0] dabs [NumComp];
	logic [27:0] mprod [NumComp];
	logic [31:0] pa, pb;

	always_comb begin
		for (int j = 0; j < NumComp; j++) begin
			dabs[j] = (xs_q >= mean_q[j]) ? xs_q - mean_q[j] : mean_q[j] - xs_q;
			mprod[j] = 28'(mult_q) * 28'(spread_q[j]);
			mt[j] = ({4'd0, dabs[j], 8'd0} < mprod[j]);
		end
	end

	// ranks are recomputed from one registered pair per cycle of the scan
	logic [CompW-1:0] cmp_a, cmp_b;
	assign pa = 32'(weight_q[cmp_a]) * 32'(spread_q[cmp_b]);
	assign pb = 32'(weight_q[cmp_b]) * 32'(spread_q[cmp_a]);

	// scan order: pairwise table of "a before b", one entry per pair of slots
	logic [NumComp-1:0] wb_q [NumComp];
	logic [NumComp-1:0] pb_q [NumComp];
	logic [CompW:0] ia_q, ib_q;
	logic tbl_done_q;

	assign cmp_a = ia_q[CompW-1:0];
	assign cmp_b = ib_q[CompW-1:0];

	// insertion sort over the pairwise tables, lower slot first on ties
	always_comb begin
		logic [CompW-1:0] wt, pt;
		logic wplaced, pplaced;
		for (int j = 0; j < NumComp; j++) begin
			word[j] = CompW'(j);
			pord[j] = CompW'(j);
		end
		for (int i = 1; i < NumComp; i++) begin
			wt = word[i];
			pt = pord[i];
			wplaced = 1'b0;
			pplaced = 1'b0;
			for (int j = i - 1; j >= 0; j--) begin
				if (!wplaced) begin
					if (wb_q[wt][word[j]]) begin
						word[j+1] = word[j];
					end else begin
						word[j+1] = wt;
						wplaced = 1'b1;
					end
				end
				if (!pplaced) begin
					if (pb_q[pt][pord[j]]) begin
						pord[j+1] = pord[j];
					end else begin
						pord[j+1] = pt;
						pplaced = 1'b1;
					end
				end
			end
			if (!wplaced) word[0] = wt;
			if (!pplaced) pord[0] = pt;
		end
		wsel = word[cnt_q[CompW-1:0]];
		psel = pord[cnt_q[CompW-1:0]];
	end

	assign st.scan_last = tbl_done_q && (cnt_q == (CompW+1)'(NumComp - 1));
	assign st.hit = hit_q;
	assign st.sum_zero = (sum_q == 18'd0);
	assign st.div_done = (dcnt_q == 6'd0);
	assign st.sqrt_done = (sbit_q == 48'd0);

	logic [47:0] trial;
	assign trial = sres_q + sbit_q;
	logic [48:0] dtrial;
	assign dtrial = {rem_q, dnum_q[47]} - {17'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= ResetMatchMult[11:0];
			alpha_q <= ResetLearnRate;
			bgfrac_q <= ResetBgFrac;
			nspread_q <= ResetNewSpread;
			nweight_q <= ResetNewWeight;
			for (int j = 0; j < NumComp; j++) begin
				mean_q[j] <= '0;
				spread_q[j] <= ResetNewSpread;
				weight_q[j] <= ResetWeight;
				wb_q[j] <= '0;
				pb_q[j] <= '0;
			end
			fg_q <= 1'b0;
			hit_q <= 1'b0;
			slot_q <= '0;
			cnt_q <= '0;
			ia_q <= '0;
			ib_q <= '0;
			tbl_done_q <= 1'b0;
			dcnt_q <= '0;
			sbit_q <= '0;
			idx_q <= '0;
			xs_q <= '0;
			cum_q <= '0;
			last_q <= '0;
			w_q <= '0;
			m_q <= '0;
			s_q <= '0;
			r_q <= '0;
			prod_q <= '0;
			v1_q <= '0;
			v2_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			quo_q <= '0;
			dnum_q <= '0;
			sv_q <= '0;
			sres_q <= '0;
			sum_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					RegMatchMult: mult_q <= cfg_data[11:0];
					RegLearnRate: alpha_q <= cfg_data;
					RegBgFrac:    bgfrac_q <= cfg_data;
					RegNewSpread: nspread_q <= cfg_data;
					RegNewWeight: nweight_q <= cfg_data;
					default: ;
				endcase
			end
			case (op)
				OP_LOAD: begin
					xs_q <= {sample, 8'd0};
					ia_q <= '0;
					ib_q <= '0;
					tbl_done_q <= 1'b0;
					cnt_q <= '0;
					cum_q <= '0;
					fg_q <= 1'b1;
				end
				OP_CLASS: begin
					if (!tbl_done_q) begin
						// build comparison tables, one pair per cycle
						wb_q[cmp_a][cmp_b] <= weight_q[cmp_a] > weight_q[cmp_b];
						pb_q[cmp_a][cmp_b] <= pa > pb;
						if (ib_q == (CompW+1)'(NumComp - 1)) begin
							ib_q <= '0;
							if (ia_q == (CompW+1)'(NumComp - 1)) tbl_done_q <= 1'b1;
							else ia_q <= ia_q + 1'b1;
						end else begin
							ib_q <= ib_q + 1'b1;
						end
					end else begin
						if (cum_q < {1'b0, bgfrac_q}) begin
							cum_q <= cum_q + {1'b0, weight_q[wsel]};
							if (mt[wsel]) fg_q <= 1'b0;
						end
						cnt_q <= (cnt_q == (CompW+1)'(NumComp - 1)) ? '0 : cnt_q + 1'b1;
						hit_q <= 1'b0;
					end
				end
				OP_PRIO: begin
					if (!hit_q && mt[psel]) begin
						hit_q <= 1'b1;
						idx_q <= psel;
					end
					last_q <= psel;
					cnt_q <= cnt_q + 1'b1;
				end
				OP_PICK: begin
					slot_q <= hit_q ? idx_q : last_q;
					if (!hit_q) idx_q <= last_q;
					prod_q <= 34'(17'(18'd65536 - {2'd0, alpha_q})) * 34'(weight_q[idx_q]);
				end
				OP_WUPD: begin
					// w' and start a*65536 / w'
					logic [34:0] t;
					t = {1'b0, prod_q} + {3'd0, alpha_q, 16'd0} + 35'd32768;
					w_q <= (t[34:16] > 19'd65535) ? 16'hFFFF : t[31:16];
					den_q <= (t[34:16] > 19'd65535) ? 32'd65535 : {16'd0, t[31:16]};
					dnum_q <= {16'd0, alpha_q, 16'd0};
					rem_q <= '0;
					quo_q <= '0;
					dcnt_q <= 6'd48;
				end
				OP_DIV: begin
					if (dtrial[48]) begin
						rem_q <= {rem_q[46:0], dnum_q[47]};
						quo_q <= {quo_q[30:0], 1'b0};
					end else begin
						rem_q <= dtrial[47:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end
					dnum_q <= {dnum_q[46:0], 1'b0};
					dcnt_q <= dcnt_q - 1'b1;
				end
				OP_RATE: begin
					if (w_q == 16'd0) r_q <= '0;
					else r_q <= (quo_q > 32'd65536) ? 17'd65536 : quo_q[16:0];
					m_q <= mean_q[idx_q];
					s_q <= spread_q[idx_q];
				end
				OP_MEAN: begin
					logic [33:0] a1, a2;
					logic [34:0] t;
					a1 = 34'(17'(18'h10000 - {1'b0, r_q})) * 34'(m_q);
					a2 = 34'(r_q) * 34'(xs_q);
					t = 35'(a1) + 35'(a2) + 35'd32768;
					m_q <= t[31:16];
					prod_q <= 34'(s_q) * 34'(s_q);
				end
				OP_VAR: begin
					logic [15:0] d;
					d = (xs_q >= m_q) ? xs_q - m_q : m_q - xs_q;
					v1_q <= 48'(prod_q[31:0]) * 48'(17'(18'h10000 - {1'b0, r_q}));
					v2_q <= 32'(d) * 32'(d);
				end
				OP_VSUM: begin
					logic [49:0] t;
					t = 50'(v1_q) + 50'(v2_q) * 50'(r_q) + 50'd32768;
					sv_q <= 48'(t[49:16]);
					sres_q <= '0;
					sbit_q <= 48'h4000_0000_0000 >> 14;
				end
				OP_SQRT: begin
					if (sv_q >= trial) begin
						sv_q <= sv_q - trial;
						sres_q <= (sres_q >> 1) + sbit_q;
					end else begin
						sres_q <= sres_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
				end
				OP_WRITE: begin
					if (hit_q) begin
						weight_q[idx_q] <= w_q;
						mean_q[idx_q] <= m_q;
						spread_q[idx_q] <= (sres_q > 48'd65535) ? 16'hFFFF : sres_q[15:0];
					end else begin
						weight_q[idx_q] <= nweight_q;
						mean_q[idx_q] <= xs_q;
						spread_q[idx_q] <= nspread_q;
					end
				end
				OP_NSUM: begin
					logic [17:0] s;
					s = '0;
					for (int j = 0; j < NumComp; j++) s = s + 18'(weight_q[j]);
					sum_q <= s;
					cnt_q <= '0;
					tbl_done_q <= 1'b1;
				end
				OP_NDIV: begin
					den_q <= 32'(sum_q);
					dnum_q <= {16'd0, weight_q[cnt_q[CompW-1:0]], 16'd0};
					rem_q <= '0;
					quo_q <= '0;
					dcnt_q <= 6'd48;
				end
				OP_NSTORE: begin
					weight_q[cnt_q[CompW-1:0]] <= (quo_q > 32'd65535) ? 16'hFFFF : quo_q[15:0];
					cnt_q <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ tb/tb_gaussian_mixture_background_model_top.sv @@
`default_nettype none
module tb_gaussian_mixture_background_model_top;
	import gmm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bit       foreground;
		bit       matched;
		bit [2:0] component_index;
	} verdict_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                valid_in = 1'b0;
	logic                ready_in;
	logic [7:0]          sample = '0;
	logic                valid_out;
	logic                ready_out = 1'b0;
	logic                foreground;
	logic                matched;
	logic [2:0]          component_index;

	verdict_t verdict_q[$];
	int       error_count = 0;
	bit       calm = 1'b0;
	int       stall_left = 0;

	logic [11:0] match_mult_r;
	logic [15:0] learn_rate_r;
	logic [15:0] bg_frac_r;
	logic [15:0] new_spread_r;
	logic [15:0] new_weight_r;
	longint unsigned comp_mean[NumComp];
	longint unsigned comp_spread[NumComp];
	longint unsigned comp_weight[NumComp];

	gaussian_mixture_background_model_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.valid_in(valid_in), .ready_in(ready_in), .sample(sample),
		.valid_out(valid_out), .ready_out(ready_out),
		.foreground(foreground), .matched(matched), .component_index(component_index)
	);

	always #5 clk = ~clk;

	function automatic bit sample_hits(longint unsigned xs, int k);
		longint unsigned d;
		d = (xs >= comp_mean[k]) ? xs - comp_mean[k] : comp_mean[k] - xs;
		return (d << 8) < longint'(match_mult_r) * comp_spread[k];
	endfunction

	function automatic bit ranks_ahead(int a, int b, bit by_prio);
		if (!by_prio)
			return comp_weight[a] > comp_weight[b];
		return comp_weight[a] * comp_spread[b] > comp_weight[b] * comp_spread[a];
	endfunction

	function automatic void order_slots(output int ord[NumComp], input bit by_prio);
		int i, j, t;
		for (i = 0; i < NumComp; i++)
			ord[i] = i;
		for (i = 1; i < NumComp; i++) begin
			t = ord[i];
			j = i - 1;
			while (j >= 0 && ranks_ahead(t, ord[j], by_prio)) begin
				ord[j+1] = ord[j];
				j--;
			end
			ord[j+1] = t;
		end
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic void pull_component(int k, longint unsigned xs);
		longint unsigned a, w, r, m, s, v, d;
		a = learn_rate_r;
		w = ((65536 - a) * comp_weight[k] + (a << 16) + 32768) >> 16;
		if (w > 65535)
			w = 65535;
		r = (w == 0) ? 0 : (a << 16) / w;
		if (r > 65536)
			r = 65536;
		m = ((65536 - r) * comp_mean[k] + r * xs + 32768) >> 16;
		s = comp_spread[k];
		d = (xs >= m) ? xs - m : m - xs;
		v = ((65536 - r) * (s * s) + r * (d * d) + 32768) >> 16;
		comp_weight[k] = w;
		comp_mean[k] = m;
		s = int_sqrt(v);
		comp_spread[k] = (s > 65535) ? 65535 : s;
	endfunction

	function automatic verdict_t classify_and_learn(logic [7:0] x);
		verdict_t vd;
		int ord[NumComp];
		longint unsigned xs, cum, sum, w;
		int k, nbg, hit, slot;
		xs = longint'(x) << 8;
		cum = 0;
		nbg = 0;
		hit = -1;
		vd.foreground = 1'b1;
		order_slots(ord, 1'b0);
		for (k = 0; k < NumComp; k++) begin
			if (cum >= bg_frac_r)
				break;
			cum += comp_weight[ord[k]];
			nbg++;
		end
		for (k = 0; k < nbg; k++)
			if (sample_hits(xs, ord[k]))
				vd.foreground = 1'b0;
		order_slots(ord, 1'b1);
		for (k = 0; k < NumComp && hit < 0; k++)
			if (sample_hits(xs, ord[k]))
				hit = ord[k];
		if (hit >= 0) begin
			slot = hit;
			pull_component(slot, xs);
		end else begin
			slot = ord[NumComp-1];
			comp_mean[slot] = xs;
			comp_spread[slot] = new_spread_r;
			comp_weight[slot] = new_weight_r;
		end
		sum = 0;
		for (k = 0; k < NumComp; k++)
			sum += comp_weight[k];
		if (sum != 0)
			for (k = 0; k < NumComp; k++) begin
				w = (comp_weight[k] << 16) / sum;
				comp_weight[k] = (w > 65535) ? 65535 : w;
			end
		vd.matched = (hit >= 0);
		vd.component_index = slot[2:0];
		return vd;
	endfunction

	task automatic report(string what, int got, int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		if (calm) begin
			ready_out <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			ready_out <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = int'($urandom_range(0, 7));
			ready_out <= 1'b0;
		end else begin
			ready_out <= 1'b1;
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && valid_out && ready_out) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: result with no request pending", $time);
				error_count++;
			end else begin
				want = verdict_q.pop_front();
				if (foreground !== want.foreground)
					report("foreground", foreground, want.foreground);
				if (matched !== want.matched)
					report("matched", matched, want.matched);
				if (component_index !== want.component_index)
					report("component_index", component_index, want.component_index);
			end
		end
	end

	task automatic send_sample(logic [7:0] x);
		int gap;
		gap = (calm || $urandom_range(0, 9) < 7) ? 0 : int'($urandom_range(1, 8));
		if (gap > 0) begin
			valid_in <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		valid_in <= 1'b1;
		sample <= x;
		do @(posedge clk); while (!ready_in);
		verdict_q.push_back(classify_and_learn(x));
	endtask

	task automatic drain();
		valid_in <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			RegMatchMult: match_mult_r = val[11:0];
			RegLearnRate: learn_rate_r = val;
			RegBgFrac:    bg_frac_r = val;
			RegNewSpread: new_spread_r = val;
			RegNewWeight: new_weight_r = val;
			default: ;
		endcase
	endtask

	task automatic test_reset_state();
		send_sample(8'd0);
		send_sample(8'd255);
		send_sample(8'd255);
		send_sample(8'd0);
		send_sample(8'd128);
		send_sample(8'd1);
		send_sample(8'd254);
		drain();
	endtask

	task automatic test_register_extremes();
		write_reg(RegMatchMult, 16'd0);
		drain();
		send_sample(8'd0);
		send_sample(8'd77);
		drain();
		write_reg(RegMatchMult, 16'hFFFF);
		write_reg(RegLearnRate, 16'hFFFF);
		write_reg(RegNewSpread, 16'd1);
		write_reg(RegNewWeight, 16'd0);
		repeat (4) send_sample(8'd200);
		drain();
		write_reg(RegBgFrac, 16'd0);
		write_reg(RegLearnRate, 16'd0);
		write_reg(RegMatchMult, 16'd1);
		write_reg(3'd7, 16'h1234);
		send_sample(8'd200);
		send_sample(8'd10);
		send_sample(8'd100);
		drain();
		write_reg(RegBgFrac, 16'hFFFF);
		write_reg(RegNewSpread, 16'hFFFF);
		write_reg(RegNewWeight, 16'hFFFF);
		write_reg(RegMatchMult, ResetMatchMult);
		send_sample(8'd30);
		send_sample(8'd31);
		send_sample(8'd240);
		send_sample(8'd128);
		drain();
	endtask

	function automatic logic [15:0] pick_value(logic [15:0] lo, logic [15:0] hi,
			logic [15:0] typ);
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			2: return 16'($urandom_range(lo, hi));
			default: return 16'($urandom_range(typ / 4, typ * 2 > hi ? hi : typ * 2));
		endcase
	endfunction

	task automatic test_random_scenes(int phases, int per_phase);
		int p, n, base, x;
		for (p = 0; p < phases; p++) begin
			write_reg(RegMatchMult, pick_value(16'd0, 16'd4095, ResetMatchMult));
			write_reg(RegLearnRate, pick_value(16'd0, 16'hFFFF, ResetLearnRate));
			write_reg(RegBgFrac, pick_value(16'd0, 16'hFFFF, ResetBgFrac));
			write_reg(RegNewSpread, pick_value(16'd1, 16'hFFFF, ResetNewSpread));
			write_reg(RegNewWeight, pick_value(16'd0, 16'hFFFF, ResetNewWeight));
			write_reg(3'($urandom_range(5, 7)), 16'($urandom));
			base = int'($urandom_range(0, 255));
			for (n = 0; n < per_phase; n++) begin
				if ($urandom_range(0, 29) == 0)
					base = int'($urandom_range(0, 255));
				if ($urandom_range(0, 6) == 0)
					x = int'($urandom_range(0, 255));
				else
					x = base + int'($urandom_range(0, 16)) - 8;
				if (x < 0)
					x = 0;
				if (x > 255)
					x = 255;
				send_sample(x[7:0]);
			end
			drain();
		end
	endtask

	task automatic test_steady_stream();
		calm = 1'b1;
		write_reg(RegMatchMult, ResetMatchMult);
		write_reg(RegLearnRate, ResetLearnRate);
		write_reg(RegBgFrac, ResetBgFrac);
		write_reg(RegNewSpread, ResetNewSpread);
		write_reg(RegNewWeight, ResetNewWeight);
		test_random_scenes(1, 150);
	endtask

	initial begin
		int k;
		match_mult_r = ResetMatchMult[11:0];
		learn_rate_r = ResetLearnRate;
		bg_frac_r = ResetBgFrac;
		new_spread_r = ResetNewSpread;
		new_weight_r = ResetNewWeight;
		for (k = 0; k < NumComp; k++) begin
			comp_mean[k] = 0;
			comp_spread[k] = ResetNewSpread;
			comp_weight[k] = ResetWeight;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_register_extremes();
		test_random_scenes(8, 190);
		test_steady_stream();
		if (error_count == 0)
			$display("** gaussian_mixture_background_model_top: PASSED **");
		else
			$display("** gaussian_mixture_background_model_top: FAILED **");
		$finish;
	end

	initial begin
		#40ms;
		$display("%0t: timeout", $time);
		$display("** gaussian_mixture_background_model_top: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
